@@ rtl/hue_step_hsv_to_rgb_unit_defines.svh @@
// Assertion macros shared by the hue step HSV to RGB unit.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef HUE_STEP_HSV_TO_RGB_UNIT_DEFINES_SVH
`define HUE_STEP_HSV_TO_RGB_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked when out of reset.
`define HSR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define HSR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HSR_ASSERT(label, clk, rst, prop, msg)
`define HSR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ rtl/hsr_pkg.sv @@
// Shared constants for the hue step HSV to RGB unit.
// Used by every stage module and the top level; depends on nothing.
`default_nettype none
package hsr_pkg;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int INDEX_W = 16;
   localparam int CSR_INDEX_W = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_BASE_HUE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SATURATION = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BRIGHTNESS = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_HUE_STEP   = 2'd3;

   // Reset values, expressed as percent of a full scale and a Q0.32 golden ratio.
   localparam logic [63:0] RESET_HUE_PCT   = 64'd69;
   localparam logic [63:0] RESET_LEVEL_PCT = 64'd99;
   localparam logic [63:0] GOLDEN_Q32      = 64'h9E37_79B9;

   // Hue sectors of the six-sector rule.
   localparam logic [2:0] SECTOR_RED_YELLOW    = 3'd0;
   localparam logic [2:0] SECTOR_YELLOW_GREEN  = 3'd1;
   localparam logic [2:0] SECTOR_GREEN_CYAN    = 3'd2;
   localparam logic [2:0] SECTOR_CYAN_BLUE     = 3'd3;
   localparam logic [2:0] SECTOR_BLUE_MAGENTA  = 3'd4;
   localparam logic [2:0] SECTOR_MAGENTA_RED   = 3'd5;
endpackage
`default_nettype wire

@@ rtl/hsr_hue_stage.sv @@
// First pipeline stage: hue = frac(base_hue + index * hue_step).
// Depends on hsr_pkg.
`default_nettype none
module hsr_hue_stage #(
   parameter int FRAC_BITS = hsr_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic [hsr_pkg::INDEX_W-1:0]  color_index,
   input  wire logic [FRAC_BITS-1:0]         base_hue,
   input  wire logic [FRAC_BITS-1:0]         hue_step,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output logic [FRAC_BITS-1:0]              hue
);
   import hsr_pkg::*;

   localparam int PROD_W = INDEX_W + FRAC_BITS;

   logic                 valid_ff;
   logic [FRAC_BITS-1:0] hue_ff, hue_in;
   logic [PROD_W-1:0]    product;

   assign in_ready = !valid_ff || out_ready;

   // Only the fraction bits survive the wrap around a full turn.
   assign product = {{FRAC_BITS{1'b0}}, color_index} * {{INDEX_W{1'b0}}, hue_step};
   assign hue_in  = product[FRAC_BITS-1:0] + base_hue;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         hue_ff <= hue_in;
      end
   end

   assign out_valid = valid_ff;
   assign hue       = hue_ff;
endmodule
`default_nettype wire

@@ rtl/hsr_sector_stage.sv @@
// Second pipeline stage: sector and fraction of 6h, and p = v(1-s).
// Depends on hsr_pkg.
`default_nettype none
module hsr_sector_stage #(
   parameter int FRAC_BITS = hsr_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [FRAC_BITS-1:0] hue,
   input  wire logic [FRAC_BITS:0]   sat_level,
   input  wire logic [FRAC_BITS:0]   val_level,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [2:0]                sector,
   output logic [FRAC_BITS-1:0]      frac,
   output logic [FRAC_BITS:0]        p_level
);
   import hsr_pkg::*;

   localparam logic [FRAC_BITS:0]   ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [FRAC_BITS+2:0] SIX = (FRAC_BITS+3)'(6);

   logic                     valid_ff;
   logic [2:0]               sector_ff;
   logic [FRAC_BITS-1:0]     frac_ff;
   logic [FRAC_BITS:0]       p_ff;
   logic [FRAC_BITS+2:0]     hue6;
   logic [2*FRAC_BITS+1:0]   p_prod;

   assign in_ready = !valid_ff || out_ready;
   assign hue6     = {3'b000, hue} * SIX;
   assign p_prod   = {{(FRAC_BITS+1){1'b0}}, val_level} *
                     {{(FRAC_BITS+1){1'b0}}, ONE - sat_level};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         sector_ff <= hue6[FRAC_BITS+2:FRAC_BITS];
         frac_ff   <= hue6[FRAC_BITS-1:0];
         p_ff      <= p_prod[2*FRAC_BITS:FRAC_BITS];
      end
   end

   assign out_valid = valid_ff;
   assign sector    = sector_ff;
   assign frac      = frac_ff;
   assign p_level   = p_ff;
endmodule
`default_nettype wire

@@ rtl/hsr_scale_stage.sv @@
// Third pipeline stage: saturation scaled by f and by (1 - f).
// Depends on hsr_pkg.
`default_nettype none
module hsr_scale_stage #(
   parameter int FRAC_BITS = hsr_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [2:0]           sector,
   input  wire logic [FRAC_BITS-1:0] frac,
   input  wire logic [FRAC_BITS:0]   p_level,
   input  wire logic [FRAC_BITS:0]   sat_level,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [2:0]                sector_out,
   output logic [FRAC_BITS:0]        p_out,
   output logic [FRAC_BITS:0]        fs_level,
   output logic [FRAC_BITS:0]        fns_level
);
   import hsr_pkg::*;

   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic                   valid_ff;
   logic [2:0]             sector_ff;
   logic [FRAC_BITS:0]     p_ff, fs_ff, fns_ff;
   logic [2*FRAC_BITS+1:0] fs_prod, fns_prod;

   assign in_ready = !valid_ff || out_ready;
   assign fs_prod  = {{(FRAC_BITS+2){1'b0}}, frac} * {{(FRAC_BITS+1){1'b0}}, sat_level};
   assign fns_prod = {{(FRAC_BITS+1){1'b0}}, ONE - {1'b0, frac}} *
                     {{(FRAC_BITS+1){1'b0}}, sat_level};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         sector_ff <= sector;
         p_ff      <= p_level;
         fs_ff     <= fs_prod[2*FRAC_BITS:FRAC_BITS];
         fns_ff    <= fns_prod[2*FRAC_BITS:FRAC_BITS];
      end
   end

   assign out_valid  = valid_ff;
   assign sector_out = sector_ff;
   assign p_out      = p_ff;
   assign fs_level   = fs_ff;
   assign fns_level  = fns_ff;
endmodule
`default_nettype wire

@@ rtl/hsr_mix_stage.sv @@
// Last pipeline stage: q and t, sector selection, and the output register.
// Depends on hsr_pkg.
`default_nettype none
module hsr_mix_stage #(
   parameter int FRAC_BITS = hsr_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic [2:0]         sector,
   input  wire logic [FRAC_BITS:0] p_level,
   input  wire logic [FRAC_BITS:0] fs_level,
   input  wire logic [FRAC_BITS:0] fns_level,
   input  wire logic [FRAC_BITS:0] val_level,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic [FRAC_BITS:0]      red,
   output logic [FRAC_BITS:0]      green,
   output logic [FRAC_BITS:0]      blue
);
   import hsr_pkg::*;

   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic                   valid_ff;
   logic [FRAC_BITS:0]     red_ff, green_ff, blue_ff;
   logic [FRAC_BITS:0]     red_in, green_in, blue_in;
   logic [FRAC_BITS:0]     q_level, t_level;
   logic [2*FRAC_BITS+1:0] q_prod, t_prod;

   assign in_ready = !valid_ff || out_ready;
   assign q_prod   = {{(FRAC_BITS+1){1'b0}}, val_level} *
                     {{(FRAC_BITS+1){1'b0}}, ONE - fs_level};
   assign t_prod   = {{(FRAC_BITS+1){1'b0}}, val_level} *
                     {{(FRAC_BITS+1){1'b0}}, ONE - fns_level};
   assign q_level  = q_prod[2*FRAC_BITS:FRAC_BITS];
   assign t_level  = t_prod[2*FRAC_BITS:FRAC_BITS];

   always_comb begin
      case (sector)
         SECTOR_RED_YELLOW: begin
            red_in = val_level; green_in = t_level; blue_in = p_level;
         end
         SECTOR_YELLOW_GREEN: begin
            red_in = q_level; green_in = val_level; blue_in = p_level;
         end
         SECTOR_GREEN_CYAN: begin
            red_in = p_level; green_in = val_level; blue_in = t_level;
         end
         SECTOR_CYAN_BLUE: begin
            red_in = p_level; green_in = q_level; blue_in = val_level;
         end
         SECTOR_BLUE_MAGENTA: begin
            red_in = t_level; green_in = p_level; blue_in = val_level;
         end
         SECTOR_MAGENTA_RED: begin
            red_in = val_level; green_in = p_level; blue_in = q_level;
         end
         // A sector past magenta cannot arise; it is mapped to black.
         default: begin
            red_in = '0; green_in = '0; blue_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign out_valid = valid_ff;
   assign red       = red_ff;
   assign green     = green_ff;
   assign blue      = blue_ff;
endmodule
`default_nettype wire

@@ rtl/hue_step_hsv_to_rgb_unit.sv @@
// Palette color generator: turns a palette index into an RGB color.
// The hue of entry n is frac(base_hue + n * hue_step); saturation and
// brightness come from registers. Colors are Q1.FRAC_BITS, full scale = 1 << FRAC_BITS.
// Input channel req_*: one color index per transaction (valid/stall).
// Output channel rsp_*: one red/green/blue transaction per index, in order.
// Configuration port csr_*: one register write per cycle with csr_write_enable;
// the user must write registers only while no transaction is in flight; the
// block does not enforce this. Throughput: one index per cycle, sustained while
// rsp_stall stays low. There is one register stage each for the hue multiply-add,
// the sector split with p, the saturation scaling, and the q/t multiply with the
// sector select that feeds the output register.
// A stalled output holds its transaction; each stage refills as soon as the one
// after it moves, so req_stall rises only once all four stages are full.
// Synchronous reset empties the pipeline and loads the register defaults:
// base hue 0.69, saturation and brightness 0.99, hue step the golden ratio conjugate.
// Depends on hsr_pkg, the four hsr stage modules and the assertion macro header.
`default_nettype none
`include "hue_step_hsv_to_rgb_unit_defines.svh"
module hue_step_hsv_to_rgb_unit #(
   parameter int FRAC_BITS = hsr_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [hsr_pkg::INDEX_W-1:0]     req_color_index,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [FRAC_BITS:0]                   rsp_red,
   output logic [FRAC_BITS:0]                   rsp_green,
   output logic [FRAC_BITS:0]                   rsp_blue,
   input  wire logic                            csr_write_enable,
   input  wire logic [hsr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [FRAC_BITS:0]              csr_write_data
);
   import hsr_pkg::*;

   localparam logic [63:0] ONE_L        = 64'd1 << FRAC_BITS;
   localparam logic [63:0] RESET_HUE_L  = (RESET_HUE_PCT * ONE_L + 64'd50) / 64'd100;
   localparam logic [63:0] RESET_LVL_L  = (RESET_LEVEL_PCT * ONE_L + 64'd50) / 64'd100;
   localparam logic [63:0] RESET_STEP_L =
      (GOLDEN_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic [FRAC_BITS-1:0] base_hue_ff, hue_step_ff;
   logic [FRAC_BITS:0]   saturation_ff, brightness_ff;
   logic [FRAC_BITS:0]   sat_level, val_level;

   logic                 s1_in_ready, s1_valid, s2_in_ready, s2_valid;
   logic                 s3_in_ready, s3_valid, s4_in_ready;
   logic [FRAC_BITS-1:0] s1_hue, s2_frac;
   logic [2:0]           s2_sector, s3_sector;
   logic [FRAC_BITS:0]   s2_p, s3_p, s3_fs, s3_fns;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_hue_ff   <= RESET_HUE_L[FRAC_BITS-1:0];
         saturation_ff <= RESET_LVL_L[FRAC_BITS:0];
         brightness_ff <= RESET_LVL_L[FRAC_BITS:0];
         hue_step_ff   <= RESET_STEP_L[FRAC_BITS-1:0];
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_BASE_HUE:   base_hue_ff   <= csr_write_data[FRAC_BITS-1:0];
            REG_SATURATION: saturation_ff <= csr_write_data;
            REG_BRIGHTNESS: brightness_ff <= csr_write_data;
            REG_HUE_STEP:   hue_step_ff   <= csr_write_data[FRAC_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Levels written above full scale count as exactly full scale.
   assign sat_level = (saturation_ff > ONE) ? ONE : saturation_ff;
   assign val_level = (brightness_ff > ONE) ? ONE : brightness_ff;

   hsr_hue_stage #(.FRAC_BITS(FRAC_BITS)) u_hue (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (s1_in_ready),
      .color_index (req_color_index),
      .base_hue    (base_hue_ff),
      .hue_step    (hue_step_ff),
      .out_valid   (s1_valid),
      .out_ready   (s2_in_ready),
      .hue         (s1_hue)
   );

   hsr_sector_stage #(.FRAC_BITS(FRAC_BITS)) u_sector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s2_in_ready),
      .hue       (s1_hue),
      .sat_level (sat_level),
      .val_level (val_level),
      .out_valid (s2_valid),
      .out_ready (s3_in_ready),
      .sector    (s2_sector),
      .frac      (s2_frac),
      .p_level   (s2_p)
   );

   hsr_scale_stage #(.FRAC_BITS(FRAC_BITS)) u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s2_valid),
      .in_ready   (s3_in_ready),
      .sector     (s2_sector),
      .frac       (s2_frac),
      .p_level    (s2_p),
      .sat_level  (sat_level),
      .out_valid  (s3_valid),
      .out_ready  (s4_in_ready),
      .sector_out (s3_sector),
      .p_out      (s3_p),
      .fs_level   (s3_fs),
      .fns_level  (s3_fns)
   );

   hsr_mix_stage #(.FRAC_BITS(FRAC_BITS)) u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s4_in_ready),
      .sector    (s3_sector),
      .p_level   (s3_p),
      .fs_level  (s3_fs),
      .fns_level (s3_fns),
      .val_level (val_level),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .red       (rsp_red),
      .green     (rsp_green),
      .blue      (rsp_blue)
   );

   assign req_stall = !s1_in_ready;

   `HSR_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "output valid after reset")
   `HSR_ASSERT(a_stall_needs_backpressure, clock, reset, req_stall |-> rsp_stall,
      "input stalled while the output side is taking transactions")
   `HSR_ASSERT(a_colors_in_range, clock, reset,
      rsp_valid |-> (rsp_red <= ONE) && (rsp_green <= ONE) && (rsp_blue <= ONE),
      "color component above full scale")
endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for hue_step_hsv_to_rgb_unit: walks a short swatch list,
// then random palette indexes across register settings. Depends on hsr_pkg and the RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB = hsr_pkg::FRAC_BITS_DEFAULT;
   localparam longint unsigned ONE = 64'd1 << FB;
   localparam longint unsigned HUE_MASK = ONE - 1;
   localparam logic [FB:0] LEVEL_ONE = 17'h10000;
   localparam logic [FB:0] LEVEL_MAX = 17'h1FFFF;
   localparam logic [FB:0] HUE_RESET = (FB+1)'((hsr_pkg::RESET_HUE_PCT * ONE + 50) / 100);
   localparam logic [FB:0] LEVEL_RESET =
      (FB+1)'((hsr_pkg::RESET_LEVEL_PCT * ONE + 50) / 100);
   localparam logic [FB:0] STEP_RESET = (FB+1)'((hsr_pkg::GOLDEN_Q32 + (ONE >> 1)) >> FB);
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_OFF_CYCLES = 48;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 130;

   typedef struct packed {
      logic [FB:0] red;
      logic [FB:0] green;
      logic [FB:0] blue;
   } rgb_type;

   typedef struct packed {
      bit      fixed;
      rgb_type want;
   } swatch_type;

   typedef struct {
      logic [FB:0] base, sat, bright, step;
      logic [15:0] index;
      bit          fixed;
      rgb_type     want;
   } swatch_row_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   logic [hsr_pkg::INDEX_W-1:0]          req_color_index;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic [FB:0]                          rsp_red;
   logic [FB:0]                          rsp_green;
   logic [FB:0]                          rsp_blue;
   logic                                 csr_write_enable;
   logic [hsr_pkg::CSR_INDEX_W-1:0]      csr_index;
   logic [FB:0]                          csr_write_data;

   // Register copies as the block sees them, updated on each write.
   logic [15:0] base_hue_q;
   logic [FB:0] saturation_q;
   logic [FB:0] brightness_q;
   logic [15:0] hue_step_q;

   swatch_type     offered_swatches[$];
   rgb_type        pending_colors[$];
   swatch_row_type swatch_rows[$];

   int  mismatches;
   int  idle_cycles;
   int  colors_checked;
   int  fixed_checked;
   int  settings_count;
   int  backed_up_cycles;
   bit  hold_request;
   bit  rsp_quiet;
   bit  req_accept;
   bit  rsp_accept;
   swatch_type got_swatch;
   rgb_type    seen;
   rgb_type    want;

   hue_step_hsv_to_rgb_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_color_index  (req_color_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Six-sector HSV to RGB on the hue of one palette entry, all products truncated.
   function automatic rgb_type hsv_color(input logic [15:0] index);
      longint unsigned s, v, h, h6, sector, f, p, q, t, r, g, b;
      rgb_type c;
      s = (saturation_q > LEVEL_ONE) ? ONE : saturation_q;
      v = (brightness_q > LEVEL_ONE) ? ONE : brightness_q;
      h = 64'(index);
      h = (h * hue_step_q + base_hue_q) & HUE_MASK;
      h6 = h * 6;
      sector = h6 >> FB;
      f = h6 & HUE_MASK;
      p = (v * (ONE - s)) >> FB;
      q = (v * (ONE - ((f * s) >> FB))) >> FB;
      t = (v * (ONE - (((ONE - f) * s) >> FB))) >> FB;
      case (sector)
         hsr_pkg::SECTOR_RED_YELLOW: begin r = v; g = t; b = p; end
         hsr_pkg::SECTOR_YELLOW_GREEN: begin r = q; g = v; b = p; end
         hsr_pkg::SECTOR_GREEN_CYAN: begin r = p; g = v; b = t; end
         hsr_pkg::SECTOR_CYAN_BLUE: begin r = p; g = q; b = v; end
         hsr_pkg::SECTOR_BLUE_MAGENTA: begin r = t; g = p; b = v; end
         hsr_pkg::SECTOR_MAGENTA_RED: begin r = v; g = p; b = q; end
         default: begin r = 0; g = 0; b = 0; end
      endcase
      c.red = r[FB:0];
      c.green = g[FB:0];
      c.blue = b[FB:0];
      return c;
   endfunction

   function automatic void check_channel(input string name, input logic [FB:0] exp_value,
                                         input logic [FB:0] act_value);
      if (exp_value !== act_value) begin
         $error("%s: expected %0d, got %0d", name, exp_value, act_value);
         mismatches++;
      end
   endfunction

   // Mostly back-to-back, sometimes a short gap, rarely a long pause.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [FB:0] pick_level();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return LEVEL_ONE;
         2: return LEVEL_MAX;
         3: return (FB+1)'($urandom_range(LEVEL_ONE + 1, LEVEL_MAX));
         4: return LEVEL_ONE - 1;
         default: return (FB+1)'($urandom_range(0, LEVEL_ONE));
      endcase
   endfunction

   // Bit 16 of a hue word is junk that the block must drop.
   function automatic logic [FB:0] pick_hue_word();
      logic [FB:0] w;
      case ($urandom_range(0, 5))
         0: w = '0;
         1: w = 17'h0FFFF;
         2: w = (FB+1)'(ONE / $urandom_range(2, 64));
         3: w = STEP_RESET;
         default: w = (FB+1)'($urandom);
      endcase
      w[FB] = 1'($urandom_range(0, 1));
      return w;
   endfunction

   task automatic add_row(input logic [FB:0] base, input logic [FB:0] sat,
                          input logic [FB:0] bright, input logic [FB:0] step,
                          input logic [15:0] index, input bit fixed, input rgb_type want_rgb);
      swatch_row_type row;
      row.base = base;
      row.sat = sat;
      row.bright = bright;
      row.step = step;
      row.index = index;
      row.fixed = fixed;
      row.want = want_rgb;
      swatch_rows.push_back(row);
   endtask

   task automatic write_reg(input logic [hsr_pkg::CSR_INDEX_W-1:0] index,
                            input logic [FB:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
   endtask

   // Registers change only with nothing in flight.
   task automatic program_palette(input logic [FB:0] base, input logic [FB:0] sat,
                                  input logic [FB:0] bright, input logic [FB:0] step);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
      write_reg(hsr_pkg::REG_BASE_HUE, base);
      write_reg(hsr_pkg::REG_SATURATION, sat);
      write_reg(hsr_pkg::REG_BRIGHTNESS, bright);
      write_reg(hsr_pkg::REG_HUE_STEP, step);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      settings_count++;
   endtask

   task automatic offer_index(input logic [15:0] index, input bit fixed,
                              input rgb_type want_rgb, input bit gaps_on);
      int gap;
      swatch_type sw;
      gap = gaps_on ? pick_gap() : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_color_index <= 16'($urandom);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_color_index <= index;
      sw.fixed = fixed;
      sw.want = want_rgb;
      offered_swatches.push_back(sw);
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               hsr_pkg::REG_BASE_HUE: base_hue_q = csr_write_data[15:0];
               hsr_pkg::REG_SATURATION: saturation_q = csr_write_data;
               hsr_pkg::REG_BRIGHTNESS: brightness_q = csr_write_data;
               hsr_pkg::REG_HUE_STEP: hue_step_q = csr_write_data[15:0];
               default: ;
            endcase
         end
         req_accept = req_valid && !req_stall;
         rsp_accept = rsp_valid && !rsp_stall;
         if (req_valid && req_stall) backed_up_cycles++;
         if (req_accept) begin
            got_swatch = offered_swatches.pop_front();
            if (got_swatch.fixed) begin
               pending_colors.push_back(got_swatch.want);
               fixed_checked++;
            end else begin
               pending_colors.push_back(hsv_color(req_color_index));
            end
         end
         if (rsp_accept) begin
            seen.red = rsp_red;
            seen.green = rsp_green;
            seen.blue = rsp_blue;
            if (pending_colors.size() == 0) begin
               $error("color transaction with none pending: r=%0d g=%0d b=%0d",
                      rsp_red, rsp_green, rsp_blue);
               mismatches++;
            end else begin
               want = pending_colors.pop_front();
               check_channel("red", want.red, seen.red);
               check_channel("green", want.green, seen.green);
               check_channel("blue", want.blue, seen.blue);
               colors_checked++;
            end
         end
         idle_cycles = (req_accept || rsp_accept) ? 0 : idle_cycles + 1;
      end
   end

   // Output side: random stall runs, plus one long hold-off on request.
   initial begin
      int free_run;
      int stall_run;
      rsp_stall = 1'b0;
      forever begin
         free_run = pick_gap() + 1;
         stall_run = rsp_quiet ? 0 : pick_gap();
         if (hold_request) begin
            stall_run = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
         end
         repeat (free_run) begin
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
         repeat (stall_run) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      logic [FB:0] cur_base, cur_sat, cur_bright, cur_step;
      logic [15:0] index;
      rgb_type     none;
      rgb_type     red_full;
      rgb_type     white_full;
      bit          gaps_on;
      int          n;

      reset = 1'b1;
      req_valid = 1'b0;
      req_color_index = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      mismatches = 0;
      idle_cycles = 0;
      colors_checked = 0;
      fixed_checked = 0;
      settings_count = 0;
      backed_up_cycles = 0;
      hold_request = 1'b0;
      rsp_quiet = 1'b0;
      base_hue_q = HUE_RESET[15:0];
      saturation_q = LEVEL_RESET;
      brightness_q = LEVEL_RESET;
      hue_step_q = STEP_RESET[15:0];
      cur_base = HUE_RESET;
      cur_sat = LEVEL_RESET;
      cur_bright = LEVEL_RESET;
      cur_step = STEP_RESET;
      none = '0;
      red_full = '{red: LEVEL_ONE, green: '0, blue: '0};
      white_full = '{red: LEVEL_ONE, green: LEVEL_ONE, blue: LEVEL_ONE};

      // Register defaults straight out of reset.
      add_row(HUE_RESET, LEVEL_RESET, LEVEL_RESET, STEP_RESET, 16'h0000, 1'b0, none);
      add_row(HUE_RESET, LEVEL_RESET, LEVEL_RESET, STEP_RESET, 16'hFFFF, 1'b0, none);
      add_row(HUE_RESET, LEVEL_RESET, LEVEL_RESET, STEP_RESET, 16'h5555, 1'b0, none);
      add_row(HUE_RESET, LEVEL_RESET, LEVEL_RESET, STEP_RESET, 16'hAAAA, 1'b0, none);
      // Hue pinned at zero: pure red, white at zero saturation, black at zero value.
      add_row('0, LEVEL_ONE, LEVEL_ONE, '0, 16'h0000, 1'b1, red_full);
      add_row('0, LEVEL_ONE, LEVEL_ONE, '0, 16'hFFFF, 1'b1, red_full);
      add_row('0, LEVEL_MAX, LEVEL_MAX, '0, 16'h1234, 1'b1, red_full);
      add_row('0, '0, LEVEL_ONE, '0, 16'h0000, 1'b1, white_full);
      add_row('0, LEVEL_ONE, '0, '0, 16'h0000, 1'b1, none);
      // Top of the magenta-red sector, levels above full scale.
      add_row(17'h0FFFF, LEVEL_MAX, LEVEL_MAX, '0, 16'h0000, 1'b0, none);
      // One hue inside each sector.
      add_row(17'd1000, LEVEL_ONE, LEVEL_ONE, '0, 16'h0000, 1'b0, none);
      add_row(17'd11923, LEVEL_ONE, LEVEL_ONE, '0, 16'h0000, 1'b0, none);
      add_row(17'd22845, LEVEL_ONE, LEVEL_ONE, '0, 16'h0000, 1'b0, none);
      add_row(17'd33768, LEVEL_ONE, LEVEL_ONE, '0, 16'h0000, 1'b0, none);
      add_row(17'd44690, LEVEL_ONE, LEVEL_ONE, '0, 16'h0000, 1'b0, none);
      add_row(17'd55613, LEVEL_ONE, LEVEL_ONE, '0, 16'h0000, 1'b0, none);
      // Largest base, step and index, so the hue wraps.
      add_row(17'h0FFFF, 17'd40000, 17'd50000, 17'h0FFFF, 16'hFFFF, 1'b0, none);
      // Six evenly spaced colors.
      for (n = 0; n < 6; n++) begin
         add_row('0, 17'd32768, 17'd40000, (FB+1)'(ONE / 6), n[15:0], 1'b0, none);
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (swatch_rows[i]) begin
         if (swatch_rows[i].base != cur_base || swatch_rows[i].sat != cur_sat ||
             swatch_rows[i].bright != cur_bright || swatch_rows[i].step != cur_step) begin
            cur_base = swatch_rows[i].base;
            cur_sat = swatch_rows[i].sat;
            cur_bright = swatch_rows[i].bright;
            cur_step = swatch_rows[i].step;
            program_palette(cur_base, cur_sat, cur_bright, cur_step);
         end
         offer_index(swatch_rows[i].index, swatch_rows[i].fixed, swatch_rows[i].want, 1'b1);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         program_palette(pick_hue_word(), pick_level(), pick_level(), pick_hue_word());
         // Phase 2 fills the pipeline behind a long output hold-off;
         // phase 5 runs both sides flat out.
         gaps_on = !(phase == 2 || phase == 5);
         rsp_quiet = (phase == 5);
         if (phase == 2) hold_request = 1'b1;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            index = ($urandom_range(0, 99) < 30) ? 16'(n % 64) : 16'($urandom);
            offer_index(index, 1'b0, none, gaps_on);
         end
      end
      rsp_quiet = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("Checked %0d colors (%0d typed in) over %0d register settings.",
               colors_checked, fixed_checked, settings_count);
      $display("Input was held back by a full pipeline for %0d cycles.", backed_up_cycles);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
